@@ src/indexed_texture_expander_macros.svh @@
// Assertion macros used by the texture expander top level.
`ifndef INDEXED_TEXTURE_EXPANDER_MACROS_SVH
`define INDEXED_TEXTURE_EXPANDER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ITX_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("texture expander check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ITX_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("texture expander check failed");

`endif

@@ src/itx_pkg.sv @@
// Shared types and constants of the indexed texture expander.
package itx_pkg;

  localparam int DIM_W  = 13;
  localparam int CFG_W  = 13;
  localparam int ADDR_W = 24;

  localparam logic [1:0] MODE_4BPP  = 2'd0;
  localparam logic [1:0] MODE_8BPP  = 2'd1;
  localparam logic [1:0] MODE_24BPP = 2'd2;
  localparam logic [1:0] MODE_32BPP = 2'd3;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PIXEL_MODE   = 2'd2;
  localparam logic [1:0] REG_FLIP_EXPAND  = 2'd3;

  // Effective frame geometry, already clamped to the supported range.
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             flip;
  } frame_cfg_t;

  // Destination of the pixel that is issued next.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              done;
  } pix_pos_t;

endpackage

@@ src/itx_palette_mem.sv @@
// Palette store: one write port and one read port with registered read data.
module itx_palette_mem #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [31:0]              wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [31:0]              rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued, so a stalled result keeps its colour.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/itx_addr_gen.sv @@
// Column and row counters with an incrementally updated destination row base.
module itx_addr_gen (
  input  logic                 clk,
  input  logic                 rst,
  input  itx_pkg::frame_cfg_t  cfg,
  input  logic                 restart,
  input  logic                 advance,
  output itx_pkg::pix_pos_t    pos
);

  import itx_pkg::*;

  logic [DIM_W-1:0]    col;
  logic [DIM_W-1:0]    row;
  logic [ADDR_W-1:0]   row_base;
  logic [ADDR_W-1:0]   start_base;
  logic [2*DIM_W-1:0]  first_prod;
  logic [ADDR_W-1:0]   first_base;
  logic                last_col;
  logic                last_row;

  // Base of the first row: zero, or the bottom row when flipping.
  assign first_prod = (2*DIM_W)'(cfg.height - DIM_W'(1)) * (2*DIM_W)'(cfg.width);
  assign first_base = cfg.flip ? first_prod[ADDR_W-1:0] : '0;

  assign last_col = ({1'b0, col} + (DIM_W+1)'(1)) >= {1'b0, cfg.width};
  assign last_row = ({1'b0, row} + (DIM_W+1)'(1)) >= {1'b0, cfg.height};

  assign pos.addr = row_base + ADDR_W'(col);
  assign pos.done = last_col && last_row;

  always_ff @(posedge clk) begin
    start_base <= first_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      row_base <= '0;
    end else if (restart) begin
      col      <= '0;
      row      <= '0;
      row_base <= first_base;
    end else if (advance) begin
      if (last_col) begin
        col <= '0;
        if (last_row) begin
          row      <= '0;
          row_base <= start_base;
        end else begin
          row      <= row + DIM_W'(1);
          row_base <= cfg.flip ? row_base - ADDR_W'(cfg.width)
                               : row_base + ADDR_W'(cfg.width);
        end
      end else begin
        col <= col + DIM_W'(1);
      end
    end
  end

endmodule

@@ src/indexed_texture_expander.sv @@
// Top level of the indexed texture expander: issue stage, palette lookup and result register.
//
// The block turns a stream of texture items into destination pixels. A palette
// item (req_type 0) writes one RGBA entry into a palette memory and produces no
// result; in 8bpp mode the entry number has bits 3 and 4 swapped on the way in.
// A pixel item (req_type 1) is decoded by pixel_mode: a 4bpp byte gives two
// results, low nibble first; 8bpp, 24bpp and 32bpp give one. With flip_expand
// set, rows are written bottom-up and indices are looked up in the palette.
// The single issue stage feeds the palette read port and issues pixel results
// at one per cycle while the result register can take them; a 4bpp pixel item
// holds the stage until both of its results have issued, and a new item can be
// taken in the cycle in which the held one finishes. A result passes the issue
// stage and then the result register before it is offered; the second result
// of a 4bpp byte follows the first. No item is taken in the cycle of a
// configuration write, in the cycle after it or in the first cycle after reset,
// while the row base is rebuilt. The palette comes up unwritten and is never
// cleared: expanding an index whose entry was never written gives an undefined
// colour. Reads and writes of the palette leave the issue stage in item order,
// at most one per cycle, so a lookup always sees every earlier write.
module indexed_texture_expander #(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_DIMENSION = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  pal_index,
  input  logic [31:0] item_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] pixel_addr,
  output logic        is_index,
  output logic [7:0]  color_index,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic        last_of_run,
  output logic        frame_done
);

  import itx_pkg::*;

`include "indexed_texture_expander_macros.svh"

  localparam int PAL_AW = $clog2(PALETTE_DEPTH);
  localparam logic [8:0]  PAL_LIMIT = 9'(PALETTE_DEPTH);
  localparam logic [15:0] DIM_LIMIT = 16'(MAX_DIMENSION);

  // Configuration registers, as written.
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [1:0]       pixel_mode;
  logic             flip_expand;
  logic             rebase;

  frame_cfg_t cfg;
  pix_pos_t   pos;

  // Issue stage: the accepted item and, for 4bpp, which nibble goes next.
  logic        s1_valid;
  logic        s1_type;
  logic [7:0]  s1_pidx;
  logic [31:0] s1_data;
  logic        s1_phase;

  // Result register.
  logic              s2_valid;
  logic [ADDR_W-1:0] s2_addr;
  logic              s2_idx_form;
  logic [7:0]        s2_index;
  logic              s2_expand;
  logic [31:0]       s2_rgba;
  logic              s2_last;
  logic              s2_done;

  logic        s2_free;
  logic        can_issue;
  logic        s1_done;
  logic        is_4bpp;
  logic        paletted;
  logic [7:0]  pix_index;
  logic        index_ok;
  logic [31:0] pass_rgba;
  logic [7:0]  wr_index;
  logic        mem_we;
  logic        mem_re;
  logic [31:0] rd_data;
  logic [31:0] color;

  // A zero dimension acts as one, and anything above the limit as the limit.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if ({3'b000, v} > DIM_LIMIT) begin
      return DIM_LIMIT[DIM_W-1:0];
    end else begin
      return v;
    end
  endfunction

  assign cfg.width  = clamp_dim(frame_width);
  assign cfg.height = clamp_dim(frame_height);
  assign cfg.flip   = flip_expand;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(1);
      frame_height <= CFG_W'(1);
      pixel_mode   <= MODE_8BPP;
      flip_expand  <= 1'b0;
      rebase       <= 1'b1;
    end else begin
      rebase <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          REG_PIXEL_MODE:   pixel_mode   <= cfg_data[1:0];
          REG_FLIP_EXPAND:  flip_expand  <= cfg_data[0];
        endcase
      end
    end
  end

  // Palette writes need no result slot; pixels issue only when the result
  // register is empty or being emptied in this cycle.
  assign is_4bpp   = (pixel_mode == MODE_4BPP);
  assign paletted  = is_4bpp || (pixel_mode == MODE_8BPP);
  assign s2_free   = !s2_valid || out_ready;
  assign can_issue = s1_valid && !rebase && (!s1_type || s2_free);
  assign s1_done   = can_issue && !(s1_type && is_4bpp && !s1_phase);
  assign in_ready  = !rebase && !cfg_we && (!s1_valid || s1_done);

  assign pix_index = is_4bpp ? (s1_phase ? {4'h0, s1_data[7:4]} : {4'h0, s1_data[3:0]})
                             : s1_data[7:0];
  assign index_ok  = {1'b0, pix_index} < PAL_LIMIT;

  always_comb begin
    unique case (pixel_mode)
      MODE_24BPP: pass_rgba = {8'h00, s1_data[23:0]};
      MODE_32BPP: pass_rgba = s1_data;
      default:    pass_rgba = '0;
    endcase
  end

  // In 8bpp mode the entry number has bits 3 and 4 exchanged.
  assign wr_index = (pixel_mode == MODE_8BPP)
                    ? {s1_pidx[7:5], s1_pidx[3], s1_pidx[4], s1_pidx[2:0]}
                    : s1_pidx;

  assign mem_we = can_issue && !s1_type && ({1'b0, wr_index} < PAL_LIMIT);
  assign mem_re = can_issue && s1_type && paletted && flip_expand && index_ok;

  itx_palette_mem #(
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_index[PAL_AW-1:0]),
    .wdata (s1_data),
    .re    (mem_re),
    .raddr (pix_index[PAL_AW-1:0]),
    .rdata (rd_data)
  );

  itx_addr_gen u_addr (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (rebase),
    .advance (can_issue && s1_type),
    .pos     (pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_phase <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (s1_done) begin
        s1_phase <= 1'b0;
      end else if (can_issue && s1_type) begin
        s1_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_type <= req_type;
      s1_pidx <= pal_index;
      s1_data <= item_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (can_issue && s1_type) begin
      s2_valid <= 1'b1;
    end else if (out_ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (can_issue && s1_type) begin
      s2_addr     <= pos.addr;
      s2_done     <= pos.done;
      s2_idx_form <= paletted && !flip_expand;
      s2_index    <= (paletted && !flip_expand) ? pix_index : 8'h00;
      s2_expand   <= paletted && flip_expand && index_ok;
      s2_rgba     <= pass_rgba;
      s2_last     <= !(is_4bpp && !s1_phase);
    end
  end

  // An index beyond the store expands to black with zero alpha.
  assign color = s2_expand ? rd_data : s2_rgba;

  assign out_valid   = s2_valid;
  assign pixel_addr  = s2_addr;
  assign is_index    = s2_idx_form;
  assign color_index = s2_index;
  assign red         = color[7:0];
  assign green       = color[15:8];
  assign blue        = color[23:16];
  assign alpha       = color[31:24];
  assign last_of_run = s2_last;
  assign frame_done  = s2_done;

  `ITX_ASSERT_NEXT(a_nibble_stays, can_issue && s1_type && is_4bpp && !s1_phase, s1_valid && s1_phase)
  `ITX_ASSERT_NEXT(a_lookup_lands, mem_re, s2_valid && s2_expand)
  `ITX_ASSERT_NEXT(a_stall_keeps_colour, s2_valid && !out_ready, $stable(rd_data))
  `ITX_ASSERT_NOW(a_no_issue_on_rebase, rebase, !can_issue && !in_ready)

endmodule
